@@ sv/lu8_pkg.sv @@
`default_nettype none

package lu8_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned NarrowW = 16;
  localparam int unsigned OwedW  = 2;

  // Bytes still owed once a lead byte has been seen.
  localparam logic [OwedW-1:0] OWED_NONE  = 2'd0;
  localparam logic [OwedW-1:0] OWED_ONE   = 2'd1;
  localparam logic [OwedW-1:0] OWED_TWO   = 2'd2;
  localparam logic [OwedW-1:0] OWED_THREE = 2'd3;

  // Lead byte prefixes.
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;

  typedef struct packed {
    logic [CpW-1:0]   partial;
    logic [OwedW-1:0] owed;
  } lu8_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
  } lu8_result_t;

endpackage

`default_nettype wire

@@ sv/lu8_step.sv @@
`default_nettype none

module lu8_step (
  input  wire lu8_pkg::lu8_state_t  state_cur,
  input  wire [7:0]                 byte_in,
  input  wire                       last_in,
  input  wire                       narrow_in,
  output lu8_pkg::lu8_state_t       state_nxt,
  output lu8_pkg::lu8_result_t      result
);
  import lu8_pkg::*;

  logic [CpW-1:0] shifted;
  logic [CpW-1:0] raw_cp;
  logic           emit;

  // Shifting left by six and keeping 21 bits drops the top six of the partial value.
  assign shifted = {state_cur.partial[CpW-7:0], byte_in[5:0]};

  always_comb begin
    state_nxt = state_cur;
    raw_cp    = '0;
    emit      = 1'b0;
    priority if (state_cur.owed != OWED_NONE) begin
      state_nxt.owed    = state_cur.owed - OWED_ONE;
      state_nxt.partial = shifted;
      if (state_cur.owed == OWED_ONE) begin
        emit              = 1'b1;
        raw_cp            = shifted;
        state_nxt.partial = '0;
      end
    end else if (!byte_in[7]) begin
      emit   = 1'b1;
      raw_cp = {{(CpW-ByteW){1'b0}}, byte_in};
    end else if (byte_in[7:5] == LEAD2_PFX) begin
      state_nxt.partial = {{(CpW-5){1'b0}}, byte_in[4:0]};
      state_nxt.owed    = OWED_ONE;
    end else if (byte_in[7:4] == LEAD3_PFX) begin
      state_nxt.partial = {{(CpW-4){1'b0}}, byte_in[3:0]};
      state_nxt.owed    = OWED_TWO;
    end else if (byte_in[7:3] == LEAD4_PFX) begin
      state_nxt.partial = {{(CpW-3){1'b0}}, byte_in[2:0]};
      state_nxt.owed    = OWED_THREE;
    end else begin
      // Stray continuation byte or 0xF8 and up: skipped.
      state_nxt = state_cur;
    end

    // The end of a buffer drops any open sequence.
    if (last_in) begin
      state_nxt.partial = '0;
      state_nxt.owed    = OWED_NONE;
    end
  end

  assign result.emit       = emit;
  assign result.code_point = narrow_in ? {{(CpW-NarrowW){1'b0}}, raw_cp[NarrowW-1:0]} : raw_cp;

endmodule

`default_nettype wire

@@ sv/lenient_utf8_decoder_core.sv @@
`default_nettype none

// Lenient UTF-8 decoder: one byte per input transaction, at most one code point per
// output transaction. A byte is registered on entry, decoded from that register against
// the open sequence state, and any code point lands in an output register; the block
// takes one byte every cycle while the output register is free or being drained, and a
// code point is presented from the output register once its final byte has passed the
// input register and the decode stage. The state update of the decode stage sets that
// rate. Continuation bytes are not checked, stray bytes are skipped, and a sequence cut
// by end_of_buffer is dropped. Writing 1 to the configuration port keeps only the low 16
// bits of each code point; write it only while the block is idle.
module lenient_utf8_decoder_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  in_byte,
  input  wire        in_end_of_buffer,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [20:0] out_code_point,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data
);
  import lu8_pkg::*;

  logic           in_vld_r;
  logic [7:0]     byte_r;
  logic           last_r;
  logic           narrow_r;
  lu8_state_t     state_r;
  lu8_state_t     state_nxt;
  lu8_result_t    result;
  logic           out_vld_r;
  logic [CpW-1:0] cp_r;
  logic           advance;

  // The decode stage moves when the output register is free or being drained.
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  lu8_step u_step (
    .state_cur (state_r),
    .byte_in   (byte_r),
    .last_in   (last_r),
    .narrow_in (narrow_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      narrow_r  <= 1'b0;
      state_r   <= '0;
    end else begin
      if (cfg_valid) begin
        narrow_r <= cfg_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_vld_r <= result.emit;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_end_of_buffer;
    end
    if (advance && result.emit) begin
      cp_r <= result.code_point;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;

endmodule

`default_nettype wire
